### src/msr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msr_pkg: shared types and constants for the modular square root block
// Status of the serial arithmetic units and the nonresidue search limit.
// ----------------------------------------------------------------------------
package msr_pkg;

    // status a serial unit reports to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // candidates tried in the nonresidue search, and the counter width
    localparam int unsigned NONRES_TRIES = 4096;
    localparam int unsigned NONRES_BITS  = 13;

endpackage
`default_nettype wire

### src/modular_square_root.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modular_square_root: Tonelli-Shanks square root modulo an odd prime
// Sequencer with a bit-serial modular multiplier and remainder unit.
// ----------------------------------------------------------------------------
// One item at a time. Each modular multiply runs on the single serial
// multiplier and each remainder on the serial divider; these set the latency.
// A typical 63-bit prime costs three modular exponentiations (one squaring per
// exponent bit plus one multiply per set bit, up to about 2*63 multiplies each),
// plus the squaring loop, which grows with the square of the power of two in
// p-1. A Jacobi symbol costs one remainder per odd step plus one sequencer step
// per halving. Even moduli and moduli below three skip the arithmetic and go
// straight to the output state. The next item can be taken while the previous
// result still waits in the output register.
module modular_square_root #(
    parameter int unsigned WORD_BITS = 63
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [WORD_BITS-1:0] i_value,
    input  wire logic [WORD_BITS-1:0] i_prime_modulus,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic      [WORD_BITS-1:0] o_root,
    output logic                      o_has_root
);
    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned CW = $clog2(W);
    localparam int unsigned NB = msr_pkg::NONRES_BITS;

    localparam logic [4:0] S_IDLE = 5'd0,  S_RED  = 5'd1,  S_JAC  = 5'd2,
                           S_JDIV = 5'd3,  S_QS   = 5'd4,  S_ZTRY = 5'd5,
                           S_PW   = 5'd6,  S_PW1  = 5'd7,  S_PW2  = 5'd8,
                           S_LOOP = 5'd9,  S_SQ   = 5'd10, S_SQR  = 5'd11,
                           S_BSQ  = 5'd12, S_BSQR = 5'd13, S_UPC  = 5'd14,
                           S_UPT  = 5'd15, S_UPR  = 5'd16, S_MWAIT = 5'd17,
                           S_DWAIT = 5'd18, S_OUT = 5'd19;

    localparam logic J_N = 1'b0, J_Z = 1'b1;
    localparam logic [1:0] P_C = 2'd0, P_T = 2'd1, P_R = 2'd2;

    logic [4:0]    r_state, n_state, r_ret, n_ret;
    logic [W-1:0]  r_p, n_p, r_n, n_n, r_q, n_q, r_z, n_z;
    logic [W-1:0]  r_c, n_c, r_t, n_t, r_r, n_r, r_t2, n_t2, r_b, n_b;
    logic [W-1:0]  r_ja, n_ja, r_jn, n_jn;
    logic [W-1:0]  r_pw_r, n_pw_r, r_pw_b, n_pw_b, r_pw_e, n_pw_e;
    logic [W-1:0]  r_ma, n_ma, r_mb, n_mb, r_dn, n_dn, r_dd, n_dd;
    logic [W-1:0]  r_res_root, n_res_root, r_root, n_root;
    logic [CW-1:0] r_s, n_s, r_i, n_i, r_kk, n_kk;
    logic [NB-1:0] r_k, n_k;
    logic [1:0]    r_pwho, n_pwho;
    logic          r_jneg, n_jneg, r_jwho, n_jwho;
    logic          r_mstart, n_mstart, r_dstart, n_dstart;
    logic          r_res_has, n_res_has, r_has, n_has, r_ovalid, n_ovalid;

    msr_pkg::t_unit_stat w_mstat, w_dstat;
    logic [W-1:0]  w_mres, w_drem;
    logic [W-1:0]  w_one;
    logic [CW:0]   w_bsum;

    assign w_one  = W'(1);
    assign w_bsum = {1'b0, r_kk} + {1'b0, r_i} + (CW+1)'(1);

    // serial arithmetic units
    msr_mulmod #(.W(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart),
        .i_a(r_ma), .i_b(r_mb), .i_m(r_p), .o_stat(w_mstat), .o_res(w_mres)
    );

    msr_divmod #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_dn), .i_den(r_dd), .o_stat(w_dstat), .o_rem(w_drem)
    );

    // sequencer
    always_comb begin
        n_state = r_state; n_ret = r_ret;
        n_p = r_p; n_n = r_n; n_q = r_q; n_z = r_z;
        n_c = r_c; n_t = r_t; n_r = r_r; n_t2 = r_t2; n_b = r_b;
        n_ja = r_ja; n_jn = r_jn; n_jneg = r_jneg; n_jwho = r_jwho;
        n_pw_r = r_pw_r; n_pw_b = r_pw_b; n_pw_e = r_pw_e; n_pwho = r_pwho;
        n_ma = r_ma; n_mb = r_mb; n_dn = r_dn; n_dd = r_dd;
        n_s = r_s; n_i = r_i; n_kk = r_kk; n_k = r_k;
        n_mstart = 1'b0; n_dstart = 1'b0;
        n_res_root = r_res_root; n_res_has = r_res_has;
        n_root = r_root; n_has = r_has; n_ovalid = r_ovalid;

        // output register
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_p = i_prime_modulus;
                    if (i_prime_modulus < W'(3) || !i_prime_modulus[0]) begin
                        n_res_root = '0; n_res_has = 1'b0; n_state = S_OUT;
                    end else begin
                        n_dn = i_value; n_dd = i_prime_modulus; n_dstart = 1'b1;
                        n_ret = S_RED; n_state = S_DWAIT;
                    end
                end
            end
            S_RED: begin
                n_n = w_drem;
                if (w_drem == '0) begin
                    n_res_root = '0; n_res_has = 1'b1; n_state = S_OUT;
                end else begin
                    n_ja = w_drem; n_jn = r_p; n_jneg = 1'b0; n_jwho = J_N;
                    n_state = S_JAC;
                end
            end
            // jacobi symbol, one reduction step per visit
            S_JAC: begin
                if (r_ja == '0) begin
                    if (r_jwho == J_N) begin
                        if (r_jn == w_one && !r_jneg) begin
                            n_q = r_p - w_one; n_s = '0; n_state = S_QS;
                        end else begin
                            n_res_root = '0; n_res_has = 1'b0; n_state = S_OUT;
                        end
                    end else if (r_jn == w_one && r_jneg) begin
                        n_pw_r = w_one; n_pw_b = r_z; n_pw_e = r_q; n_pwho = P_C;
                        n_state = S_PW;
                    end else begin
                        n_z = r_z + w_one; n_k = r_k + 1'b1; n_state = S_ZTRY;
                    end
                end else if (!r_ja[0]) begin
                    n_ja = {1'b0, r_ja[W-1:1]};
                    if (r_jn[2:0] == 3'd3 || r_jn[2:0] == 3'd5) begin
                        n_jneg = ~r_jneg;
                    end
                end else begin
                    if (r_jn[1:0] == 2'd3 && r_ja[1:0] == 2'd3) begin
                        n_jneg = ~r_jneg;
                    end
                    n_jn = r_ja;
                    n_dn = r_jn; n_dd = r_ja; n_dstart = 1'b1;
                    n_ret = S_JDIV; n_state = S_DWAIT;
                end
            end
            S_JDIV: begin
                n_ja = w_drem; n_state = S_JAC;
            end
            // strip factors of two from p-1
            S_QS: begin
                if (!r_q[0]) begin
                    n_q = {1'b0, r_q[W-1:1]}; n_s = r_s + 1'b1;
                end else begin
                    n_z = W'(2); n_k = '0; n_state = S_ZTRY;
                end
            end
            S_ZTRY: begin
                if (r_k < NB'(msr_pkg::NONRES_TRIES) && r_z < r_p) begin
                    n_ja = r_z; n_jn = r_p; n_jneg = 1'b0; n_jwho = J_Z;
                    n_state = S_JAC;
                end else begin
                    n_res_root = '0; n_res_has = 1'b0; n_state = S_OUT;
                end
            end
            // modular exponentiation, exponent bits LSB first
            S_PW: begin
                if (r_pw_e == '0) begin
                    unique case (r_pwho)
                        P_C: begin
                            n_c = r_pw_r;
                            n_pw_r = w_one; n_pw_b = r_n; n_pw_e = r_q; n_pwho = P_T;
                        end
                        P_T: begin
                            n_t = r_pw_r;
                            n_pw_r = w_one; n_pw_b = r_n;
                            n_pw_e = (r_q + w_one) >> 1; n_pwho = P_R;
                        end
                        default: begin
                            n_r = r_pw_r; n_state = S_LOOP;
                        end
                    endcase
                end else if (r_pw_e[0]) begin
                    n_ma = r_pw_r; n_mb = r_pw_b; n_mstart = 1'b1;
                    n_ret = S_PW1; n_state = S_MWAIT;
                end else begin
                    n_ma = r_pw_b; n_mb = r_pw_b; n_mstart = 1'b1;
                    n_ret = S_PW2; n_state = S_MWAIT;
                end
            end
            S_PW1: begin
                n_pw_r = w_mres;
                n_ma = r_pw_b; n_mb = r_pw_b; n_mstart = 1'b1;
                n_ret = S_PW2; n_state = S_MWAIT;
            end
            S_PW2: begin
                n_pw_b = w_mres; n_pw_e = {1'b0, r_pw_e[W-1:1]}; n_state = S_PW;
            end
            // main tonelli-shanks loop
            S_LOOP: begin
                if (r_t == '0) begin
                    n_res_root = '0; n_res_has = 1'b0; n_state = S_OUT;
                end else if (r_t == w_one) begin
                    n_res_root = r_r; n_res_has = 1'b1; n_state = S_OUT;
                end else begin
                    n_t2 = r_t; n_i = CW'(1); n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (r_i < r_s) begin
                    n_ma = r_t2; n_mb = r_t2; n_mstart = 1'b1;
                    n_ret = S_SQR; n_state = S_MWAIT;
                end else begin
                    n_res_root = '0; n_res_has = 1'b0; n_state = S_OUT;
                end
            end
            S_SQR: begin
                n_t2 = w_mres;
                if (w_mres == w_one) begin
                    n_b = r_c; n_kk = '0; n_state = S_BSQ;
                end else begin
                    n_i = r_i + 1'b1; n_state = S_SQ;
                end
            end
            S_BSQ: begin
                n_ma = r_b; n_mb = r_b; n_mstart = 1'b1; n_state = S_MWAIT;
                if (w_bsum < {1'b0, r_s}) begin
                    n_ret = S_BSQR;
                end else begin
                    n_s = r_i; n_ret = S_UPC;
                end
            end
            S_BSQR: begin
                n_b = w_mres; n_kk = r_kk + 1'b1; n_state = S_BSQ;
            end
            S_UPC: begin
                n_c = w_mres;
                n_ma = r_t; n_mb = w_mres; n_mstart = 1'b1;
                n_ret = S_UPT; n_state = S_MWAIT;
            end
            S_UPT: begin
                n_t = w_mres;
                n_ma = r_r; n_mb = r_b; n_mstart = 1'b1;
                n_ret = S_UPR; n_state = S_MWAIT;
            end
            S_UPR: begin
                n_r = w_mres; n_state = S_LOOP;
            end
            S_MWAIT: begin
                if (w_mstat.done) begin
                    n_state = r_ret;
                end
            end
            S_DWAIT: begin
                if (w_dstat.done) begin
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_root = r_res_root; n_has = r_res_has; n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mstart <= n_mstart;
            r_dstart <= n_dstart;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ret <= n_ret; r_p <= n_p; r_n <= n_n; r_q <= n_q; r_z <= n_z;
        r_c <= n_c; r_t <= n_t; r_r <= n_r; r_t2 <= n_t2; r_b <= n_b;
        r_ja <= n_ja; r_jn <= n_jn; r_jneg <= n_jneg; r_jwho <= n_jwho;
        r_pw_r <= n_pw_r; r_pw_b <= n_pw_b; r_pw_e <= n_pw_e; r_pwho <= n_pwho;
        r_ma <= n_ma; r_mb <= n_mb; r_dn <= n_dn; r_dd <= n_dd;
        r_s <= n_s; r_i <= n_i; r_kk <= n_kk; r_k <= n_k;
        r_res_root <= n_res_root; r_res_has <= n_res_has;
        r_root <= n_root; r_has <= n_has;
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_root     = r_root;
    assign o_has_root = r_has;

    // the two serial units never run at once
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mstat.busy && w_dstat.busy)) else $error("both serial units busy");

    // a multiply is only launched into its wait state
    a_mul_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mstart |-> r_state == S_MWAIT) else $error("multiply started outside wait");

    // a finished multiply is always collected
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mstat.done |-> r_state == S_MWAIT) else $error("multiply result dropped");

    // no root reported without the flag
    a_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_root) |-> o_root == '0) else $error("root without flag");
endmodule
`default_nettype wire

### src/msr_mulmod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msr_mulmod: bit-serial modular multiplier
// Computes a*b mod m by double-and-add, multiplier bits shifted out MSB first,
// one doubling and one conditional addition per bit.
// ----------------------------------------------------------------------------
module msr_mulmod #(
    parameter int unsigned W = 63
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [W-1:0]      i_a,
    input  wire logic [W-1:0]      i_b,
    input  wire logic [W-1:0]      i_m,
    output msr_pkg::t_unit_stat    o_stat,
    output logic      [W-1:0]      o_res
);
    localparam int unsigned CW = $clog2(W);

    logic [W-1:0]  r_acc, r_b, r_a, r_m;
    logic [CW-1:0] r_cnt;
    logic          r_phase, r_busy, r_done;
    logic [W:0]    w_sum;
    logic [W-1:0]  w_addend, w_red;

    // one modular addition: doubling in phase 0, adding a in phase 1
    always_comb begin
        w_addend = r_phase ? r_a : r_acc;
        w_sum    = {1'b0, r_acc} + {1'b0, w_addend};
        w_red    = (w_sum >= {1'b0, r_m}) ? W'(w_sum - {1'b0, r_m}) : w_sum[W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= '0;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    if (r_cnt == CW'(W - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_acc <= w_red;
            end else begin
                if (r_b[W-1]) begin
                    r_acc <= w_red;
                end
                r_b <= {r_b[W-2:0], 1'b0};
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_res  = r_acc;
endmodule
`default_nettype wire

### src/msr_divmod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msr_divmod: bit-serial remainder unit
// Restoring division that keeps only the remainder; the dividend is shifted
// in one bit per cycle.
// ----------------------------------------------------------------------------
module msr_divmod #(
    parameter int unsigned W = 63
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [W-1:0]      i_num,
    input  wire logic [W-1:0]      i_den,
    output msr_pkg::t_unit_stat    o_stat,
    output logic      [W-1:0]      o_rem
);
    localparam int unsigned CW = $clog2(W);

    logic [W-1:0]  r_rem, r_num, r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    w_trial;

    // shift in the next dividend bit
    assign w_trial = {r_rem, r_num[W-1]};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= W'(w_trial - {1'b0, r_den});
            end else begin
                r_rem <= w_trial[W-1:0];
            end
            r_num <= {r_num[W-2:0], 1'b0};
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

### tb/sv/tb_modular_square_root.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_square_root: self-checking bench for the modular square root
// Feeds value/modulus pairs through valid/ready, predicts each root with an
// independent Tonelli-Shanks model and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_modular_square_root;

    localparam int unsigned WB         = 63;
    localparam int unsigned IDLE_LIMIT = 2000000;
    localparam int unsigned TAIL_WAIT  = 500;
    localparam int unsigned PHASE_LEN  = 32;

    typedef struct {
        logic [WB-1:0] value;
        logic [WB-1:0] modulus;
    } t_sqrt_req;

    typedef struct {
        logic [WB-1:0] root;
        logic          has_root;
    } t_sqrt_res;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [WB-1:0] i_value;
    logic [WB-1:0] i_prime_modulus;
    logic          o_valid;
    logic          i_ready;
    logic [WB-1:0] o_root;
    logic          o_has_root;

    t_sqrt_req pending_items[$];
    t_sqrt_res expected_roots[$];
    int        sent_count;
    int        fail_count;
    int        total_items;
    int unsigned idle_cycles;

    modular_square_root #(.WORD_BITS(WB)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_value         (i_value),
        .i_prime_modulus (i_prime_modulus),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_root          (o_root),
        .o_has_root      (o_has_root)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // modular arithmetic, operands below m < 2^63
    function automatic logic [63:0] add_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [63:0] s;
        s = a + b;
        return (s >= m) ? s - m : s;
    endfunction

    function automatic logic [63:0] mul_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd0;
        for (int k = 63; k >= 0; k--) begin
            acc = add_m(acc, acc, m);
            if (b[k]) acc = add_m(acc, a, m);
        end
        return acc;
    endfunction

    function automatic logic [63:0] pow_m(logic [63:0] base, logic [63:0] e, logic [63:0] m);
        logic [63:0] r;
        r = 64'd1 % m;
        while (e != 0) begin
            if (e[0]) r = mul_m(r, base, m);
            base = mul_m(base, base, m);
            e = e >> 1;
        end
        return r;
    endfunction

    // jacobi symbol from residues mod 8 and mod 4
    function automatic int jacobi_sym(logic [63:0] a, logic [63:0] n);
        int          sgn;
        logic [63:0] tmp;
        sgn = 1;
        a = a % n;
        while (a != 0) begin
            while (!a[0]) begin
                a = a >> 1;
                if (n[2:0] == 3'd3 || n[2:0] == 3'd5) sgn = -sgn;
            end
            tmp = a; a = n; n = tmp;
            if (a[1:0] == 2'd3 && n[1:0] == 2'd3) sgn = -sgn;
            a = a % n;
        end
        return (n == 1) ? sgn : 0;
    endfunction

    // expected root for one request
    function automatic t_sqrt_res predict_root(t_sqrt_req rq);
        logic [63:0] p, n, q, z, c, t, r, b, t2;
        int          s, i, k;
        bit          found;
        t_sqrt_res   res;
        res.root = '0;
        res.has_root = 1'b0;
        p = {1'b0, rq.modulus};
        n = {1'b0, rq.value};
        if (p < 3 || !p[0]) return res;
        n = n % p;
        if (n == 0) begin
            res.has_root = 1'b1;
            return res;
        end
        if (jacobi_sym(n, p) != 1) return res;
        q = p - 1;
        s = 0;
        while (!q[0]) begin
            q = q >> 1;
            s++;
        end
        // first candidate from two upwards with symbol minus one
        found = 1'b0;
        z = 64'd2;
        for (k = 0; k < msr_pkg::NONRES_TRIES && z < p; k++) begin
            if (jacobi_sym(z, p) == -1) begin
                found = 1'b1;
                break;
            end
            z++;
        end
        if (!found) return res;
        c = pow_m(z, q, p);
        t = pow_m(n, q, p);
        r = pow_m(n, (q + 1) >> 1, p);
        while (1) begin
            if (t == 0) return res;
            if (t == 1) begin
                res.root = r[WB-1:0];
                res.has_root = 1'b1;
                return res;
            end
            t2 = t;
            found = 1'b0;
            for (i = 1; i < s; i++) begin
                t2 = mul_m(t2, t2, p);
                if (t2 == 1) begin
                    found = 1'b1;
                    break;
                end
            end
            if (!found) return res;
            b = c;
            for (k = 0; k + i + 1 < s; k++) b = mul_m(b, b, p);
            s = i;
            c = mul_m(b, b, p);
            t = mul_m(t, c, p);
            r = mul_m(r, b, p);
        end
    endfunction

    // deterministic miller-rabin for operands below 2^63
    function automatic bit is_prime(logic [63:0] n);
        int          bases[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        logic [63:0] d, x;
        int          s;
        bit          witness;
        if (n < 2) return 1'b0;
        foreach (bases[j]) begin
            if (n == bases[j]) return 1'b1;
            if (n % bases[j] == 0) return 1'b0;
        end
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        foreach (bases[j]) begin
            x = pow_m(bases[j], d, n);
            if (x == 1 || x == n - 1) continue;
            witness = 1'b1;
            for (int r = 1; r < s; r++) begin
                x = mul_m(x, x, n);
                if (x == n - 1) begin
                    witness = 1'b0;
                    break;
                end
            end
            if (witness) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [62:0] rand63();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[62:0];
    endfunction

    // random prime with the given bit length
    function automatic logic [63:0] rand_prime(int bits);
        logic [63:0] n;
        n = {1'b0, rand63()};
        if (bits < 63) n = n & ((64'd1 << bits) - 1);
        n[bits-1] = 1'b1;
        n[0] = 1'b1;
        if (bits == 63 && n > 64'h7fff_ffff_ffff_ff00) n = 64'h7fff_ffff_ffff_ff00 | 64'd1;
        while (!is_prime(n)) n = n + 2;
        return n;
    endfunction

    // value congruent to a square mod p, half the time lifted by a random multiple of p
    function automatic logic [62:0] square_val(logic [63:0] p);
        logic [63:0] x, r, span;
        x = {1'b0, rand63()} % p;
        r = mul_m(x, x, p);
        span = (64'h7fff_ffff_ffff_ffff - r) / p;
        if ($urandom_range(1, 0)) r = r + p * ({$urandom, $urandom} % (span + 1));
        return r[62:0];
    endfunction

    task automatic add_item(logic [63:0] v, logic [63:0] p);
        t_sqrt_req rq;
        rq.value = v[WB-1:0];
        rq.modulus = p[WB-1:0];
        pending_items.push_back(rq);
    endtask

    // request source: directed corners then random sequences
    task automatic build_items();
        logic [63:0] p;
        int          kind;
        add_item(64'd5, 64'd0);
        add_item(64'd1, 64'd1);
        add_item(64'd3, 64'd2);
        add_item(64'd7, 64'd4);
        add_item(64'd0, 64'd3);
        add_item(64'd1, 64'd3);
        add_item(64'd2, 64'd3);
        add_item(64'h7fff_ffff_ffff_ffff, 64'd7);
        add_item(64'd21, 64'd7);
        add_item(64'd4, 64'd9);
        add_item(64'd6, 64'd25);
        add_item(64'd4, 64'd15);
        add_item(64'd10, 64'd13);
        add_item(64'd3, 64'd998244353);
        add_item(64'd5, 64'd3221225473);
        add_item(64'd9, 64'd7340033);
        add_item({1'b0, square_val(64'd7340033)}, 64'd7340033);
        add_item({1'b0, square_val(64'd3221225473)}, 64'd3221225473);
        add_item(64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffe7);
        add_item(64'd0, 64'h7fff_ffff_ffff_ffe7);
        add_item({1'b0, square_val(64'h7fff_ffff_ffff_ffe7)}, 64'h7fff_ffff_ffff_ffe7);
        add_item(64'd2, 64'h7fff_ffff_ffff_ffff);
        add_item(64'h5555_5555_5555_5555, 64'h2aaa_aaaa_aaaa_aaab);
        for (int j = 0; j < 80; j++) begin
            kind = $urandom_range(99, 0);
            if (kind < 85) begin
                // well-formed: prime modulus, mostly small, a few wide (40 to 63 bits)
                if (kind < 8) p = rand_prime($urandom_range(63, 40));
                else if (kind < 25) p = rand_prime($urandom_range(32, 17));
                else p = rand_prime($urandom_range(16, 3));
                if ($urandom_range(3, 0) != 0) add_item({1'b0, square_val(p)}, p);
                else add_item({1'b0, rand63()}, p);
            end else if (kind < 92) begin
                // odd modulus, usually composite
                p = {1'b0, rand63()};
                p[0] = 1'b1;
                add_item({1'b0, rand63()}, p);
            end else begin
                // even or tiny modulus
                p = {1'b0, rand63()};
                if (kind < 96) p[0] = 1'b0;
                else p = $urandom_range(2, 0);
                add_item({1'b0, rand63()}, p);
            end
        end
    endtask

    // idling phase by number of transfers so far
    function automatic int phase_of(int n);
        return (n / PHASE_LEN) % 4;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        logic      nxt_valid;
        t_sqrt_req rq;
        int        ph;
        nxt_valid = i_valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_roots.push_back(predict_root(pending_items.pop_front()));
                sent_count++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_items.size() != 0) begin
                ph = phase_of(sent_count);
                if (ph == 1) nxt_valid = ($urandom_range(99, 0) >= 50);
                else if (ph == 3) nxt_valid = ($urandom_range(99, 0) >= 19);
                else nxt_valid = 1'b1;
                if (nxt_valid) begin
                    rq = pending_items[0];
                    i_value <= rq.value;
                    i_prime_modulus <= rq.modulus;
                end
            end
        end
        i_valid <= nxt_valid;
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_sqrt_res ex;
        int        ph;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_roots.size() == 0) begin
                    $error("unexpected result transfer root=%0h has_root=%0b",
                           o_root, o_has_root);
                    fail_count++;
                end else begin
                    ex = expected_roots.pop_front();
                    if (o_root !== ex.root) begin
                        $error("root: expected %0h actual %0h", ex.root, o_root);
                        fail_count++;
                    end
                    if (o_has_root !== ex.has_root) begin
                        $error("has_root: expected %0b actual %0b", ex.has_root, o_has_root);
                        fail_count++;
                    end
                end
            end
            ph = phase_of(sent_count);
            if (ph == 2) i_ready <= ($urandom_range(99, 0) >= 50);
            else if (ph == 3) i_ready <= ($urandom_range(99, 0) >= 19);
            else i_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // reset, stimulus and end of run
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_value = '0;
        i_prime_modulus = '0;
        sent_count = 0;
        fail_count = 0;
        idle_cycles = 0;
        build_items();
        total_items = pending_items.size();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (sent_count == total_items && expected_roots.size() == 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (expected_roots.size() != 0) begin
            $error("results still expected at end: %0d", expected_roots.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### modular_square_root.f
src/msr_pkg.sv
src/msr_mulmod.sv
src/msr_divmod.sv
src/modular_square_root.sv
tb/sv/tb_modular_square_root.sv
